### hw/rtl/adit_pkg.sv
package adit_pkg;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// input beat kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_NO_SPACE = 2'd2;

	localparam int VALUE_W = 64;

	// classification queue depth
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// character class as seen by the back end
	typedef enum logic [2:0] {
		CLS_WS,
		CLS_DIGIT,
		CLS_PLUS,
		CLS_MINUS,
		CLS_OTHER,
		CLS_END
	} cls_t;

	// token parse phase
	typedef enum logic [1:0] {
		PH_SKIP,
		PH_SIGN,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
	} q_entry_t;

	// front to queue write side
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	// queue to back read side
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

endpackage

### hw/rtl/adit_in_if.sv
interface adit_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_byte;

	modport source (output valid, output kind, output char_byte, input ready);
	modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

### hw/rtl/adit_out_if.sv
interface adit_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

### hw/rtl/ascii_decimal_integer_tokenizer.sv
// Decimal integer tokenizer: one beat per clock carries a character byte or an
// end-of-data mark, and a beat is taken every cycle while the four-entry class
// queue has room. The front end classifies the byte (whitespace, digit, sign,
// other, end) against the signed_mode register and queues it; the back end
// consumes one queued beat per cycle, keeping the token state and the running
// acc * 10 + digit. A token result (value, status) is loaded into the output
// register when the back end takes the beat ending it from the queue head, after
// any older beats ahead of it; the back end pauses only when a new result
// meets an unaccepted one. Write signed_mode only while idle.
module ascii_decimal_integer_tokenizer (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	adit_in_if.sink   tok_in,
	adit_out_if.source tok_out
);
	import adit_pkg::*;

	q_push_t push;
	q_head_t head;
	logic    q_full;
	logic    pop;

	adit_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.tok_in    (tok_in)
	);

	adit_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	adit_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.tok_out (tok_out)
	);

endmodule

### hw/rtl/adit_front.sv
module adit_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                q_full,
	output adit_pkg::q_push_t   push,
	adit_in_if.sink             tok_in
);
	import adit_pkg::*;

	logic signed_mode_q;
	logic is_ws;
	logic is_digit;
	cls_t cls;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b1;
		end else if (cfg_we) begin
			signed_mode_q <= cfg_wdata;
		end
	end

	// classify the incoming beat
	always_comb begin
		is_ws = (tok_in.char_byte == CH_SPACE) || (tok_in.char_byte == CH_TAB) ||
			(tok_in.char_byte == CH_CR) || (tok_in.char_byte == CH_LF);
		is_digit = (tok_in.char_byte >= CH_ZERO) && (tok_in.char_byte <= CH_NINE);
		if (tok_in.kind == KIND_END) begin
			cls = CLS_END;
		end else if (is_ws) begin
			cls = CLS_WS;
		end else if (is_digit) begin
			cls = CLS_DIGIT;
		end else if (signed_mode_q && tok_in.char_byte == CH_PLUS) begin
			cls = CLS_PLUS;
		end else if (signed_mode_q && tok_in.char_byte == CH_MINUS) begin
			cls = CLS_MINUS;
		end else begin
			cls = CLS_OTHER;
		end
	end

	assign tok_in.ready      = !q_full;
	assign push.valid        = tok_in.valid && !q_full;
	assign push.entry.cls    = cls;
	// '0'..'9' carry their value in the low nibble
	assign push.entry.digit  = tok_in.char_byte[3:0];

endmodule

### hw/rtl/adit_queue.sv
module adit_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  adit_pkg::q_push_t   push,
	input  logic                pop,
	output logic                full,
	output adit_pkg::q_head_t   head
);
	import adit_pkg::*;

	q_entry_t          entries_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     count_q;
	logic              do_pop;

	assign full       = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = entries_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + (Q_AW+1)'(1);
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - (Q_AW+1)'(1);
			end
		end
	end

endmodule

### hw/rtl/adit_back.sv
module adit_back (
	input  logic                clk,
	input  logic                arst_n,
	input  adit_pkg::q_head_t   head,
	output logic                pop,
	adit_out_if.source          tok_out
);
	import adit_pkg::*;

	phase_t                phase_q;
	phase_t                phase_d;
	logic [VALUE_W-1:0]    acc_q;
	logic [VALUE_W-1:0]    acc_d;
	logic                  neg_q;
	logic                  neg_d;
	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic [1:0]            out_status_q;
	logic                  emit;
	logic [VALUE_W-1:0]    emit_value;
	logic [1:0]            emit_status;
	logic [VALUE_W-1:0]    acc_next;
	logic [VALUE_W-1:0]    token_value;

	// acc * 10 + digit as two shifted adds
	assign acc_next    = (acc_q << 3) + (acc_q << 1) + VALUE_W'(head.entry.digit);
	assign token_value = neg_q ? (VALUE_W'(0) - acc_q) : acc_q;

	// next phase and result
	always_comb begin
		phase_d     = phase_q;
		acc_d       = acc_q;
		neg_d       = neg_q;
		emit        = 1'b0;
		emit_value  = '0;
		emit_status = ST_OK;
		case (phase_q)
			PH_SKIP: begin
				case (head.entry.cls)
					CLS_WS, CLS_END: begin
					end
					CLS_DIGIT: begin
						acc_d   = VALUE_W'(head.entry.digit);
						neg_d   = 1'b0;
						phase_d = PH_DIGITS;
					end
					CLS_PLUS, CLS_MINUS: begin
						acc_d   = '0;
						neg_d   = (head.entry.cls == CLS_MINUS);
						phase_d = PH_SIGN;
					end
					default: begin
						emit        = 1'b1;
						emit_status = ST_INVALID;
					end
				endcase
			end
			PH_SIGN: begin
				if (head.entry.cls == CLS_DIGIT) begin
					acc_d   = VALUE_W'(head.entry.digit);
					phase_d = PH_DIGITS;
				end else begin
					emit        = 1'b1;
					emit_status = ST_INVALID;
				end
			end
			PH_DIGITS: begin
				case (head.entry.cls)
					CLS_DIGIT: begin
						acc_d = acc_next;
					end
					CLS_WS, CLS_END: begin
						emit       = 1'b1;
						emit_value = token_value;
					end
					default: begin
						emit        = 1'b1;
						emit_status = ST_NO_SPACE;
					end
				endcase
			end
			default: begin
				phase_d = PH_SKIP;
			end
		endcase
		// any result closes the token
		if (emit) begin
			phase_d = PH_SKIP;
			acc_d   = '0;
			neg_d   = 1'b0;
		end
	end

	// take the head beat unless its result has nowhere to go
	assign pop = head.valid && (!emit || !out_valid_q || tok_out.ready);

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
		end else if (pop) begin
			phase_q <= phase_d;
		end
	end

	// token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			neg_q <= 1'b0;
		end else if (pop) begin
			acc_q <= acc_d;
			neg_q <= neg_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (tok_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_value_q  <= emit_value;
			out_status_q <= emit_status;
		end
	end

	assign tok_out.valid  = out_valid_q;
	assign tok_out.value  = out_value_q;
	assign tok_out.status = out_status_q;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import adit_pkg::*;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [1:0]         status;
	} token_t;

	// directed stimulus row; a typed row carries the result it must give
	typedef struct packed {
		logic               kind;
		logic [7:0]         ch;
		logic               typed;
		logic [VALUE_W-1:0] value;
		logic [1:0]         status;
	} stim_row_t;

	localparam int N_DIRECTED  = 24;
	localparam int N_PHASES    = 5;
	localparam int PHASE_BEATS = 150;
	localparam int SETTLE      = 12;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	adit_in_if  in_bus ();
	adit_out_if out_bus ();

	ascii_decimal_integer_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.tok_in    (in_bus),
		.tok_out   (out_bus)
	);

	// mirror of the token state
	phase_t             tok_phase;
	logic [VALUE_W-1:0] tok_acc;
	logic               tok_neg;
	logic               sign_allowed;

	token_t due_tokens[$];
	int     mismatches;
	int     burst_left;
	int     stall_mode;
	int     stall_left;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{KIND_END,  8'h00,    1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, CH_SPACE, 1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, CH_TAB,   1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, CH_CR,    1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, CH_LF,    1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, 8'h78,    1'b1, 64'd0, ST_INVALID},
		'{KIND_CHAR, CH_PLUS,  1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, CH_SPACE, 1'b1, 64'd0, ST_INVALID},
		'{KIND_CHAR, CH_MINUS, 1'b0, 64'd0, ST_OK},
		'{KIND_END,  8'hA5,    1'b1, 64'd0, ST_INVALID},
		'{KIND_CHAR, CH_ZERO,  1'b0, 64'd0, ST_OK},
		'{KIND_END,  8'hFF,    1'b1, 64'd0, ST_OK},
		'{KIND_CHAR, CH_MINUS, 1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, CH_NINE,  1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, CH_SPACE, 1'b1, 64'hFFFF_FFFF_FFFF_FFF7, ST_OK},
		'{KIND_CHAR, 8'h37,    1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, 8'h61,    1'b1, 64'd0, ST_NO_SPACE},
		'{KIND_CHAR, CH_PLUS,  1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, 8'h35,    1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, CH_LF,    1'b1, 64'd5, ST_OK},
		'{KIND_CHAR, 8'hFF,    1'b1, 64'd0, ST_INVALID},
		'{KIND_CHAR, 8'h00,    1'b1, 64'd0, ST_INVALID},
		'{KIND_CHAR, CH_MINUS, 1'b0, 64'd0, ST_OK},
		'{KIND_CHAR, CH_MINUS, 1'b1, 64'd0, ST_INVALID}
	};

	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// close the current token and clear the state
	function automatic token_t close_token(input logic [VALUE_W-1:0] v, input logic [1:0] st);
		token_t t;
		t.value   = v;
		t.status  = st;
		tok_phase = PH_SKIP;
		tok_acc   = '0;
		tok_neg   = 1'b0;
		return t;
	endfunction

	// advance the token state by one beat; hit flags a result
	function automatic void tokenize_beat(input logic kind, input logic [7:0] c,
			output logic hit, output token_t res);
		logic [VALUE_W-1:0] d;
		d   = VALUE_W'(c - CH_ZERO);
		hit = 1'b0;
		res = '0;
		if (tok_phase != PH_SIGN && tok_phase != PH_DIGITS)
			tok_phase = PH_SKIP;
		if (kind == KIND_END) begin
			if (tok_phase == PH_SIGN) begin
				hit = 1'b1;
				res = close_token('0, ST_INVALID);
			end else if (tok_phase == PH_DIGITS) begin
				hit = 1'b1;
				res = close_token(tok_neg ? -tok_acc : tok_acc, ST_OK);
			end
		end else if (tok_phase == PH_SKIP) begin
			if (is_digit(c)) begin
				tok_acc   = d;
				tok_neg   = 1'b0;
				tok_phase = PH_DIGITS;
			end else if (sign_allowed && (c == CH_MINUS || c == CH_PLUS)) begin
				tok_acc   = '0;
				tok_neg   = (c == CH_MINUS);
				tok_phase = PH_SIGN;
			end else if (!is_space(c)) begin
				hit = 1'b1;
				res = close_token('0, ST_INVALID);
			end
		end else if (tok_phase == PH_SIGN) begin
			if (is_digit(c)) begin
				tok_acc   = d;
				tok_phase = PH_DIGITS;
			end else begin
				hit = 1'b1;
				res = close_token('0, ST_INVALID);
			end
		end else begin
			if (is_digit(c)) begin
				tok_acc = tok_acc * 10 + d;
			end else if (is_space(c)) begin
				hit = 1'b1;
				res = close_token(tok_neg ? -tok_acc : tok_acc, ST_OK);
			end else begin
				hit = 1'b1;
				res = close_token('0, ST_NO_SPACE);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// compare one accepted result beat with the oldest one due
	task automatic check_token();
		token_t want;
		if (due_tokens.size() == 0) begin
			report_mismatch("result beat with none due", out_bus.value, '0);
			return;
		end
		want = due_tokens.pop_front();
		if (out_bus.value !== want.value)
			report_mismatch("value", out_bus.value, want.value);
		if (out_bus.status !== want.status)
			report_mismatch("status", 64'(out_bus.status), 64'(want.status));
	endtask

	// drive one input beat in bursts with random gaps, then predict
	task automatic send_beat(input logic kind, input logic [7:0] c,
			input logic typed = 1'b0, input token_t typed_res = '0);
		logic   hit;
		token_t res;
		int     gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
				: $urandom_range(0, 3);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_bus.valid     <= 1'b1;
		in_bus.kind      <= kind;
		in_bus.char_byte <= c;
		do @(posedge clk); while (!in_bus.ready);
		tokenize_beat(kind, c, hit, res);
		if (typed)
			due_tokens.push_back(typed_res);
		else if (hit)
			due_tokens.push_back(res);
	endtask

	// hold the sender until every result is in and the block has drained
	task automatic settle_idle();
		in_bus.valid <= 1'b0;
		burst_left = 0;
		while (due_tokens.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we       <= 1'b0;
		sign_allowed = m;
	endtask

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// one token with random content; some are broken or plain noise
	task automatic send_token(inout int beats);
		int r;
		int ndig;
		repeat ($urandom_range(0, 2)) begin
			send_beat(KIND_CHAR, pick_space());
			beats++;
		end
		r = $urandom_range(0, 99);
		if (r < 8) begin
			send_beat(KIND_CHAR, 8'($urandom_range(0, 255)));
			beats++;
		end else if (r < 12) begin
			send_beat(KIND_END, 8'($urandom_range(0, 255)));
			beats++;
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				send_beat(KIND_CHAR, $urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
				beats++;
			end
			r = $urandom_range(0, 9);
			ndig = (r < 7) ? $urandom_range(1, 4)
				: (r < 9) ? $urandom_range(5, 19) : $urandom_range(20, 25);
			for (int i = 0; i < ndig; i++) begin
				if ($urandom_range(0, 99) < 3)
					send_beat(KIND_CHAR, 8'($urandom_range(0, 255)));
				else
					send_beat(KIND_CHAR, CH_ZERO + 8'($urandom_range(0, 9)));
				beats++;
			end
			r = $urandom_range(0, 9);
			if (r < 6)
				send_beat(KIND_CHAR, pick_space());
			else if (r < 8)
				send_beat(KIND_END, 8'($urandom_range(0, 255)));
			else
				send_beat(KIND_CHAR, 8'($urandom_range(0, 255)));
			beats++;
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side: check accepted beats, stall on a pattern of its own
	always @(posedge clk) begin
		if (arst_n && out_bus.valid && out_bus.ready)
			check_token();
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 64);
		end
		stall_left--;
		case (stall_mode)
			0: out_bus.ready <= 1'b1;
			1: out_bus.ready <= 1'($urandom_range(0, 1));
			2: out_bus.ready <= ($urandom_range(0, 3) == 0);
			default: out_bus.ready <= ~out_bus.ready;
		endcase
	end

	// stimulus
	initial begin
		int   beats;
		logic m;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = 1'b0;
		in_bus.valid     = 1'b0;
		in_bus.kind      = KIND_CHAR;
		in_bus.char_byte = 8'h00;
		out_bus.ready    = 1'b0;
		stall_left       = 0;
		stall_mode       = 0;
		burst_left       = 0;
		mismatches       = 0;
		tok_phase        = PH_SKIP;
		tok_acc          = '0;
		tok_neg          = 1'b0;
		sign_allowed     = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, signed mode from reset
		foreach (directed_rows[i])
			send_beat(directed_rows[i].kind, directed_rows[i].ch, directed_rows[i].typed,
				'{directed_rows[i].value, directed_rows[i].status});
		settle_idle();

		// random part: both modes forced first, then chosen at random
		for (int p = 0; p < N_PHASES; p++) begin
			m = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
			write_mode(m);
			beats = 0;
			while (beats < PHASE_BEATS)
				send_token(beats);
			settle_idle();
		end

		if (mismatches == 0)
			$display("ascii_decimal_integer_tokenizer test passed");
		else
			$display("ascii_decimal_integer_tokenizer test failed");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("ascii_decimal_integer_tokenizer test failed");
		$finish;
	end

endmodule
